/* sv/pairwise_gravity_acceleration_macros.svh */
// ---------------------------------------------------------------------------
// Pairwise gravity acceleration assertion macros
// Shared concurrent assertion forms for the pairwise gravity block.
// ---------------------------------------------------------------------------
`ifndef PAIRWISE_GRAVITY_ACCELERATION_MACROS_SVH
`define PAIRWISE_GRAVITY_ACCELERATION_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PGA_ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PGA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* sv/pga_pkg.sv */
// ---------------------------------------------------------------------------
// Pairwise gravity acceleration package
// Stage map, constants and the per-stage record of the pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package pga_pkg;

  localparam int NumAxes    = 3;
  localparam int NumLanes   = 6;
  localparam int NumStages  = 73;
  localparam int SqrtFirst  = 3;
  localparam int SqrtLast   = 35;
  localparam int MulStage   = 36;
  localparam int NumStage   = 37;
  localparam int OvfStage   = 38;
  localparam int DivFirst   = 39;
  localparam int DivLast    = 71;
  localparam int OutStage   = 72;

  localparam logic [31:0] GConstReset = 32'd65536;

  typedef struct packed {
    logic [2:0]              neg;
    logic [2:0]              nz;
    logic [2:0][31:0]        absd;
    logic [31:0]             a_mass;
    logic [31:0]             b_mass;
    logic [63:0]             gma;
    logic [63:0]             gmb;
    logic [2:0][63:0]        sq;
    logic [65:0]             r2;
    logic [67:0]             srem;
    logic [32:0]             root;
    logic [65:0]             dlo;
    logic [65:0]             dhi;
    logic [5:0][63:0]        pl;
    logic [5:0][63:0]        ph;
    logic [98:0]             den;
    logic [5:0][127:0]       drem;
    logic [5:0][32:0]        quo;
    logic [5:0]              ovf;
    logic [5:0][31:0]        acc;
    logic                    coinc;
    logic                    sat;
  } pga_stage_t;

endpackage

`default_nettype wire

/* sv/pga_ifs.sv */
// ---------------------------------------------------------------------------
// Pairwise gravity acceleration channels
// Valid/ready channel interfaces for pairs, results and the constant write.
// ---------------------------------------------------------------------------
`default_nettype none

interface pga_in_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_pos_x;
  logic signed [31:0] a_pos_y;
  logic signed [31:0] a_pos_z;
  logic signed [31:0] b_pos_x;
  logic signed [31:0] b_pos_y;
  logic signed [31:0] b_pos_z;
  logic [31:0]        a_mass;
  logic [31:0]        b_mass;
  modport source (output valid, a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z,
                  a_mass, b_mass, input ready);
  modport sink (input valid, a_pos_x, a_pos_y, a_pos_z, b_pos_x, b_pos_y, b_pos_z,
                a_mass, b_mass, output ready);
endinterface

interface pga_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] a_accel_x;
  logic signed [31:0] a_accel_y;
  logic signed [31:0] a_accel_z;
  logic signed [31:0] b_accel_x;
  logic signed [31:0] b_accel_y;
  logic signed [31:0] b_accel_z;
  logic               coincident;
  logic               saturated;
  modport source (output valid, a_accel_x, a_accel_y, a_accel_z, b_accel_x, b_accel_y,
                  b_accel_z, coincident, saturated, input ready);
  modport sink (input valid, a_accel_x, a_accel_y, a_accel_z, b_accel_x, b_accel_y,
                b_accel_z, coincident, saturated, output ready);
endinterface

interface pga_cfg_if;
  logic        valid;
  logic        ready;
  logic [31:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface

`default_nettype wire

/* sv/pga_flow_ctrl.sv */
// ---------------------------------------------------------------------------
// Pairwise gravity flow control
// Per-stage advance enables for a bubble-collapsing pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

module pga_flow_ctrl (
  input  wire logic [pga_pkg::NumStages-1:0] valid,
  input  wire logic                          out_ready,
  output logic      [pga_pkg::NumStages-1:0] en
);

  // A stage may load when any stage at or below it is empty, or the
  // result is being taken this cycle.
  for (genvar k = 0; k < pga_pkg::NumStages; k++) begin : g_en
    assign en[k] = out_ready || !(&valid[pga_pkg::NumStages-1:k]);
  end

endmodule

`default_nettype wire

/* sv/pairwise_gravity_acceleration.sv */
// ---------------------------------------------------------------------------
// Pairwise gravity acceleration
// Streaming N-body pair kernel: one pair of bodies in, two accelerations out.
// ---------------------------------------------------------------------------
// The block takes one pair of bodies per clock unless all stages are full and
// the result is held, and presents after 73 register stages the acceleration
// of each body toward the other (G*m/r^2 along the unit separation vector,
// Q16.16), a coincident flag when both positions match and a saturated flag
// when a component was clipped. The depth is set by the 33 one-bit stages of
// the distance square root and the 33 one-bit stages of the six parallel
// quotient lanes; a new pair may enter every cycle on that condition, and a
// stalled result only holds the stages it blocks, so bubbles are squeezed out.
// The user must write the gravitational constant through the cfg channel only
// while no pair is in flight; the block does not enforce it. It resets to 1.0.
// ---------------------------------------------------------------------------
`default_nettype none
`include "pairwise_gravity_acceleration_macros.svh"

module pairwise_gravity_acceleration (
  input  wire logic  clk,
  input  wire logic  rst_n,
  pga_in_if.sink     in_ch,
  pga_out_if.source  out_ch,
  pga_cfg_if.sink    cfg_ch
);

  localparam int NS = pga_pkg::NumStages;

  logic [31:0]         gconst_r;
  logic [NS-1:0]       v_r;
  logic [NS-1:0]       en;
  pga_pkg::pga_stage_t st_r [NS];

  // The constant register takes every write transfer.
  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gconst_r <= pga_pkg::GConstReset;
    end else if (cfg_ch.valid) begin
      gconst_r <= cfg_ch.data;
    end
  end

  pga_flow_ctrl u_flow (
    .valid     (v_r),
    .out_ready (out_ch.ready),
    .en        (en)
  );

  assign in_ch.ready = en[0];

  for (genvar k = 0; k < NS; k++) begin : g_stage
    pga_pkg::pga_stage_t stage_nxt;

    if (k == 0) begin : g_in
      // Separation d = B - A per axis, kept as sign, nonzero and magnitude.
      always_comb begin
        logic [32:0] diff [3];
        stage_nxt = '0;
        diff[0] = {in_ch.b_pos_x[31], in_ch.b_pos_x} - {in_ch.a_pos_x[31], in_ch.a_pos_x};
        diff[1] = {in_ch.b_pos_y[31], in_ch.b_pos_y} - {in_ch.a_pos_y[31], in_ch.a_pos_y};
        diff[2] = {in_ch.b_pos_z[31], in_ch.b_pos_z} - {in_ch.a_pos_z[31], in_ch.a_pos_z};
        for (int i = 0; i < 3; i++) begin
          stage_nxt.neg[i]  = diff[i][32];
          stage_nxt.nz[i]   = (diff[i] != '0);
          stage_nxt.absd[i] = diff[i][32] ? 32'(-diff[i]) : diff[i][31:0];
        end
        stage_nxt.a_mass = in_ch.a_mass;
        stage_nxt.b_mass = in_ch.b_mass;
      end
    end else if (k == 1) begin : g_sq
      // Squared components and the two G*m products.
      always_comb begin
        stage_nxt = st_r[k-1];
        for (int i = 0; i < 3; i++) begin
          stage_nxt.sq[i] = {32'b0, st_r[k-1].absd[i]} * {32'b0, st_r[k-1].absd[i]};
        end
        stage_nxt.gma = {32'b0, gconst_r} * {32'b0, st_r[k-1].a_mass};
        stage_nxt.gmb = {32'b0, gconst_r} * {32'b0, st_r[k-1].b_mass};
      end
    end else if (k == 2) begin : g_r2
      always_comb begin
        stage_nxt      = st_r[k-1];
        stage_nxt.r2   = {2'b0, st_r[k-1].sq[0]} + {2'b0, st_r[k-1].sq[1]}
                       + {2'b0, st_r[k-1].sq[2]};
        stage_nxt.srem = {2'b0, stage_nxt.r2};
        stage_nxt.root = '0;
      end
    end else if (k >= pga_pkg::SqrtFirst && k <= pga_pkg::SqrtLast) begin : g_sqrt
      // One root bit per stage: keep the remainder r2 - root^2 and try
      // setting the next lower bit.
      localparam int Bit = pga_pkg::SqrtLast - k;
      always_comb begin
        logic [67:0] trial;
        stage_nxt = st_r[k-1];
        trial = ({35'b0, st_r[k-1].root} << (Bit + 1)) + (68'd1 << (2 * Bit));
        if (st_r[k-1].srem >= trial) begin
          stage_nxt.srem      = st_r[k-1].srem - trial;
          stage_nxt.root[Bit] = 1'b1;
        end
      end
    end else if (k == pga_pkg::MulStage) begin : g_mul
      // Partial products of r2*r and of G*m*|d|, each about 32 by 32 bits.
      always_comb begin
        logic [63:0] gm;
        stage_nxt     = st_r[k-1];
        stage_nxt.dlo = {33'b0, st_r[k-1].r2[32:0]} * {33'b0, st_r[k-1].root};
        stage_nxt.dhi = {33'b0, st_r[k-1].r2[65:33]} * {33'b0, st_r[k-1].root};
        for (int j = 0; j < 6; j++) begin
          gm = (j < 3) ? st_r[k-1].gmb : st_r[k-1].gma;
          stage_nxt.pl[j] = {32'b0, gm[31:0]} * {32'b0, st_r[k-1].absd[j % 3]};
          stage_nxt.ph[j] = {32'b0, gm[63:32]} * {32'b0, st_r[k-1].absd[j % 3]};
        end
      end
    end else if (k == pga_pkg::NumStage) begin : g_num
      // Denominator r^2*r and the numerators G*m*|d|*2^32.
      always_comb begin
        logic [95:0] prod;
        stage_nxt     = st_r[k-1];
        stage_nxt.den = {st_r[k-1].dhi, 33'b0} + {33'b0, st_r[k-1].dlo};
        for (int j = 0; j < 6; j++) begin
          prod = {st_r[k-1].ph[j], 32'b0} + {32'b0, st_r[k-1].pl[j]};
          stage_nxt.drem[j] = {prod, 32'b0};
        end
      end
    end else if (k == pga_pkg::OvfStage) begin : g_ovf
      // A quotient of 2^33 or more is out of range whatever its sign.
      always_comb begin
        stage_nxt = st_r[k-1];
        for (int j = 0; j < 6; j++) begin
          stage_nxt.ovf[j] = ({4'b0, st_r[k-1].drem[j]} >= {st_r[k-1].den, 33'b0});
          stage_nxt.quo[j] = '0;
        end
      end
    end else if (k >= pga_pkg::DivFirst && k <= pga_pkg::DivLast) begin : g_div
      // Restoring division, one quotient bit per stage in all six lanes.
      localparam int Bit = pga_pkg::DivLast - k;
      always_comb begin
        logic [131:0] trial;
        stage_nxt = st_r[k-1];
        trial = {33'b0, st_r[k-1].den} << Bit;
        for (int j = 0; j < 6; j++) begin
          if ({4'b0, st_r[k-1].drem[j]} >= trial) begin
            stage_nxt.drem[j]     = st_r[k-1].drem[j] - trial[127:0];
            stage_nxt.quo[j][Bit] = 1'b1;
          end
        end
      end
    end else begin : g_out
      // Sign, clipping, massless bodies and the coincident case.
      always_comb begin
        logic        negl;
        logic        massok;
        logic        big;
        logic [32:0] limit;
        logic [32:0] mag;
        stage_nxt       = st_r[k-1];
        stage_nxt.coinc = (st_r[k-1].r2 == '0);
        stage_nxt.sat   = 1'b0;
        for (int j = 0; j < 6; j++) begin
          if (j < 3) begin
            negl   = st_r[k-1].neg[j % 3];
            massok = (st_r[k-1].a_mass != '0);
          end else begin
            negl   = !st_r[k-1].neg[j % 3] && st_r[k-1].nz[j % 3];
            massok = (st_r[k-1].b_mass != '0);
          end
          limit = negl ? 33'h0_8000_0000 : 33'h0_7FFF_FFFF;
          big   = st_r[k-1].ovf[j] || (st_r[k-1].quo[j] > limit);
          mag   = big ? limit : st_r[k-1].quo[j];
          if (stage_nxt.coinc || !massok) begin
            stage_nxt.acc[j] = '0;
          end else begin
            stage_nxt.acc[j] = negl ? 32'(-mag) : mag[31:0];
            stage_nxt.sat    = stage_nxt.sat | big;
          end
        end
      end
    end

    always_ff @(posedge clk) begin
      if (en[k]) begin
        st_r[k] <= stage_nxt;
      end
    end

    if (k == 0) begin : g_v0
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= in_ch.valid;
        end
      end
    end else begin : g_vk
      always_ff @(posedge clk) begin
        if (!rst_n) begin
          v_r[k] <= 1'b0;
        end else if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  assign out_ch.valid      = v_r[NS-1];
  assign out_ch.a_accel_x  = st_r[NS-1].acc[0];
  assign out_ch.a_accel_y  = st_r[NS-1].acc[1];
  assign out_ch.a_accel_z  = st_r[NS-1].acc[2];
  assign out_ch.b_accel_x  = st_r[NS-1].acc[3];
  assign out_ch.b_accel_y  = st_r[NS-1].acc[4];
  assign out_ch.b_accel_z  = st_r[NS-1].acc[5];
  assign out_ch.coincident = st_r[NS-1].coinc;
  assign out_ch.saturated  = st_r[NS-1].sat;

  // An empty output stage means the whole pipeline can move.
  `PGA_ASSERT_IMPLIES(a_ready_when_drained, clk, rst_n, !v_r[NS-1], in_ch.ready, "pipeline refused a pair while output empty")
  // An input transfer always lands in the first stage.
  `PGA_ASSERT_NEXT(a_accept_lands, clk, rst_n, in_ch.valid && in_ch.ready, v_r[0], "accepted pair lost at entry")
  // Coincident bodies give all-zero, unsaturated results.
  `PGA_ASSERT_IMPLIES(a_coinc_zero, clk, rst_n, out_ch.valid && out_ch.coincident, out_ch.a_accel_x == 0 && out_ch.a_accel_y == 0 && out_ch.a_accel_z == 0 && out_ch.b_accel_x == 0 && out_ch.b_accel_y == 0 && out_ch.b_accel_z == 0 && !out_ch.saturated, "coincident result not zero")

endmodule

`default_nettype wire

/* tb/pga_checker.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pairwise gravity acceleration checker
// Watches the pair, result and constant channels. It predicts each body pair's
// accelerations in exact fixed point and compares every result transfer.
// ---------------------------------------------------------------------------
`default_nettype none

module pga_checker (
  input  wire logic clk,
  input  wire logic rst_n,
  pga_in_if         in_ch,
  pga_out_if        out_ch,
  pga_cfg_if        cfg_ch,
  output int        fail_count,
  output int        pending
);

  typedef struct {
    logic [5:0][31:0] accel;
    logic             coinc;
    logic             sat;
  } accel_pair_t;

  accel_pair_t accel_queue[$];
  logic [31:0] grav_const;

  // Signed Q16.16 bits from an unsigned magnitude, clipped to the output range.
  function automatic logic [31:0] clip_accel(input logic [127:0] mag, input logic neg,
                                             inout logic sat);
    logic [127:0] limit;
    logic [31:0]  m;
    limit = neg ? 128'h8000_0000 : 128'h7FFF_FFFF;
    if (mag > limit) begin
      sat = 1'b1;
      m   = limit[31:0];
    end else begin
      m = mag[31:0];
    end
    return neg ? -m : m;
  endfunction

  function automatic accel_pair_t predict_accel(input logic [5:0][31:0] pos,
                                                input logic [31:0] a_m, input logic [31:0] b_m,
                                                input logic [31:0] g);
    accel_pair_t  res;
    logic [33:0]  d [3];
    logic [32:0]  ad [3];
    logic [65:0]  r2;
    logic [33:0]  root;
    logic [33:0]  cand;
    logic [98:0]  den;
    logic [63:0]  gma;
    logic [63:0]  gmb;
    logic [127:0] q;
    res.accel = '0;
    res.coinc = 1'b0;
    res.sat   = 1'b0;
    r2 = '0;
    for (int i = 0; i < 3; i++) begin
      d[i]  = {{2{pos[3+i][31]}}, pos[3+i]} - {{2{pos[i][31]}}, pos[i]};
      ad[i] = d[i][33] ? 33'(-d[i]) : d[i][32:0];
      r2    = r2 + 66'(ad[i]) * 66'(ad[i]);
    end
    if (r2 == '0) begin
      res.coinc = 1'b1;
      return res;
    end
    // Integer square root, one bit at a time from the top.
    root = '0;
    for (int b = 33; b >= 0; b--) begin
      cand = root | (34'd1 << b);
      if (68'(cand) * 68'(cand) <= 68'(r2)) root = cand;
    end
    den = 99'(r2) * 99'(root);
    gma = 64'(g) * 64'(a_m);
    gmb = 64'(g) * 64'(b_m);
    for (int i = 0; i < 3; i++) begin
      if (a_m != 0) begin
        q = ((128'(gmb) * 128'(ad[i])) << 32) / 128'(den);
        res.accel[i] = clip_accel(q, d[i][33], res.sat);
      end
      if (b_m != 0) begin
        q = ((128'(gma) * 128'(ad[i])) << 32) / 128'(den);
        res.accel[3+i] = clip_accel(q, !d[i][33] && d[i] != 0, res.sat);
      end
    end
    return res;
  endfunction

  always @(posedge clk) begin
    accel_pair_t      got;
    accel_pair_t      want;
    logic [5:0][31:0] pos;
    if (!rst_n) begin
      grav_const = 32'd65536;
      accel_queue.delete();
      fail_count = 0;
    end else begin
      if (cfg_ch.valid && cfg_ch.ready) grav_const = cfg_ch.data;
      if (in_ch.valid && in_ch.ready) begin
        pos = {in_ch.b_pos_z, in_ch.b_pos_y, in_ch.b_pos_x,
               in_ch.a_pos_z, in_ch.a_pos_y, in_ch.a_pos_x};
        accel_queue = {accel_queue,
                       predict_accel(pos, in_ch.a_mass, in_ch.b_mass, grav_const)};
      end
      if (out_ch.valid && out_ch.ready) begin
        got.accel = {out_ch.b_accel_z, out_ch.b_accel_y, out_ch.b_accel_x,
                     out_ch.a_accel_z, out_ch.a_accel_y, out_ch.a_accel_x};
        got.coinc = out_ch.coincident;
        got.sat   = out_ch.saturated;
        if (accel_queue.size() == 0) begin
          fail_count++;
          if (fail_count <= 10) $display("%0t: result transfer with no pair pending", $realtime);
        end else begin
          want = accel_queue.pop_front();
          if (got.accel !== want.accel || got.coinc !== want.coinc || got.sat !== want.sat) begin
            fail_count++;
            if (fail_count <= 10)
              $display("%0t: mismatch accel exp %h got %h, coinc exp %b got %b, sat exp %b got %b",
                       $realtime, want.accel, got.accel, want.coinc, got.coinc,
                       want.sat, got.sat);
          end
        end
      end
    end
    pending <= accel_queue.size();
  end

endmodule

`default_nettype wire

/* tb/tb_pairwise_gravity_acceleration.sv */
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// Pairwise gravity acceleration testbench
// Drives directed and random body pairs under several gravitational constants,
// with random idling on both channels, a long result hold-off and a full drain.
// ---------------------------------------------------------------------------
`default_nettype none

module tb_pairwise_gravity_acceleration;

  localparam int DrainCycles = 90;    // pipeline is 73 deep; allow some margin
  localparam int HoldCycles  = 200;
  localparam int StallLimit  = 5000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  int   fail_count;
  int   pending;
  int   stall_cycles = 0;

  // Idling is enabled by the sender; the receiver holds off on request.
  logic gaps_on = 1'b1;
  int   hold_reqs = 0;

  pga_in_if  in_ch ();
  pga_out_if out_ch ();
  pga_cfg_if cfg_ch ();

  pairwise_gravity_acceleration dut (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  pga_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .cfg_ch    (cfg_ch),
    .fail_count(fail_count),
    .pending   (pending)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // Offers one pair starting at a falling edge and returns at the falling edge
  // after its transfer. Random gaps drop valid before the pair goes out.
  task automatic send_pair(input logic [31:0] ax, input logic [31:0] ay,
                           input logic [31:0] az, input logic [31:0] bx,
                           input logic [31:0] by, input logic [31:0] bz,
                           input logic [31:0] ma, input logic [31:0] mb);
    while (gaps_on && $urandom_range(99) < 28) begin
      in_ch.valid = 1'b0;
      @(negedge clk);
    end
    in_ch.a_pos_x = ax;
    in_ch.a_pos_y = ay;
    in_ch.a_pos_z = az;
    in_ch.b_pos_x = bx;
    in_ch.b_pos_y = by;
    in_ch.b_pos_z = bz;
    in_ch.a_mass  = ma;
    in_ch.b_mass  = mb;
    in_ch.valid   = 1'b1;
    do @(posedge clk); while (!in_ch.ready);
    @(negedge clk);
  endtask

  // Stops offering pairs until every result is back, then lets the pipeline
  // run empty, since the constant may only change with nothing in flight.
  task automatic drain;
    in_ch.valid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic write_gravity(input logic [31:0] g);
    drain();
    cfg_ch.data  = g;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
    cfg_ch.valid = 1'b0;
  endtask

  function automatic logic [31:0] pick_mass();
    case ($urandom_range(5))
      0:       return 32'd0;
      1:       return $urandom_range(1, 16);
      2:       return $urandom_range(1, 4096);
      3:       return $urandom;
      4:       return 32'hFFFF_FFFF;
      default: return $urandom_range(1, 300);
    endcase
  endfunction

  // Most pairs sit close together so the accelerations stay in range; the
  // rest are far apart, coincident or share some coordinates.
  task automatic send_random_pair;
    logic [31:0] a [3];
    logic [31:0] b [3];
    int          mode;
    mode = $urandom_range(9);
    for (int i = 0; i < 3; i++) begin
      a[i] = $urandom;
      if (mode < 6) b[i] = a[i] + ($signed($urandom) >>> $urandom_range(6, 31));
      else if (mode < 8) b[i] = $urandom;
      else if (mode == 8) b[i] = a[i];
      else b[i] = $urandom_range(1) ? a[i] : a[i] + ($signed($urandom) >>> 12);
    end
    if (mode == 8 && $urandom_range(1)) b[$urandom_range(2)] ^= 32'd1 << $urandom_range(31);
    send_pair(a[0], a[1], a[2], b[0], b[1], b[2], pick_mass(), pick_mass());
  endtask

  // Result side: random ready, with one long hold-off for each request the
  // sender raises.
  initial begin
    int holds_done;
    holds_done   = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_reqs != holds_done) begin
        holds_done++;
        out_ch.ready = 1'b0;
        repeat (HoldCycles) @(negedge clk);
      end else begin
        out_ch.ready = !gaps_on || $urandom_range(99) >= 28;
      end
    end
  end

  // Watchdog: too many cycles in a row without any transfer ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
          (cfg_ch.valid && cfg_ch.ready)) begin
        stall_cycles <= 0;
      end else if (stall_cycles >= StallLimit) begin
        $display("Regression FAIL");
        $finish;
      end else begin
        stall_cycles <= stall_cycles + 1;
      end
    end
  end

  initial begin
    logic [31:0] gravities [6];
    in_ch.valid   = 1'b0;
    in_ch.a_pos_x = '0;
    in_ch.a_pos_y = '0;
    in_ch.a_pos_z = '0;
    in_ch.b_pos_x = '0;
    in_ch.b_pos_y = '0;
    in_ch.b_pos_z = '0;
    in_ch.a_mass  = '0;
    in_ch.b_mass  = '0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.data   = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Directed pairs under the reset constant of 1.0.
    send_pair(32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
              32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'd1, 32'd1);
    // Coincident bodies, at zero and at the extremes.
    send_pair('0, '0, '0, '0, '0, '0, 32'd5, 32'd7);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF,
              32'h8000_0000, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    // Massless bodies, one side at a time and both.
    send_pair('0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd0, 32'd10);
    send_pair('0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd10, 32'd0);
    send_pair('0, '0, '0, 32'h0001_0000, 32'h0002_0000, 32'h0003_0000, 32'd0, 32'd0);
    // Separation along one axis only, either direction: zero components.
    send_pair('0, '0, '0, 32'h0005_0000, '0, '0, 32'd3, 32'd4);
    send_pair('0, '0, '0, '0, 32'hFFFB_0000, '0, 32'd3, 32'd4);
    send_pair('0, 32'h0001_0000, '0, '0, 32'h0001_0000, 32'h0010_0000, 32'd100, 32'd2);
    // Smallest separation with heavy masses: clips both ways.
    send_pair('0, '0, '0, 32'd1, 32'hFFFF_FFFF, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
    send_pair(32'h1234_5678, 32'h9ABC_DEF0, 32'h0F0F_0F0F,
              32'h1234_5679, 32'h9ABC_DEF0, 32'h0F0F_0F0E, 32'd1, 32'd1);
    // Unit masses a unit apart, and a mid-range case.
    send_pair('0, '0, '0, 32'h0001_0000, '0, '0, 32'd1, 32'd1);
    send_pair(32'hFFF0_0000, 32'h0010_0000, 32'h0000_8000,
              32'h0020_0000, 32'hFFE0_0000, 32'h0004_0000, 32'd500000, 32'd12345);

    // Random phases, each under its own constant, extremes included.
    gravities = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd1, 32'd256, $urandom};
    for (int p = 0; p < 6; p++) begin
      write_gravity(gravities[p]);
      gaps_on = (p != 3);
      for (int n = 0; n < 140; n++) begin
        // Long result hold-off while pairs keep coming, so the block backs up.
        if (p == 1 && n == 40) hold_reqs++;
        // Sender waits for every outstanding result before going on.
        if (p == 2 && n == 70) drain();
        send_random_pair();
      end
    end
    gaps_on = 1'b1;

    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
